/* sv/counting_semaphore_fifo_wait_core_macros.svh */
// Assertion macros for the counting semaphore core.
`ifndef COUNTING_SEMAPHORE_FIFO_WAIT_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_FIFO_WAIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CSFW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csfw assertion failed");
`define CSFW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csfw assertion failed");
`else
`define CSFW_ASSERT_IMP(label, ante, cons)
`define CSFW_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* sv/csfw_pkg.sv */
// Types and constants shared by the counting semaphore core.
`timescale 1ns / 1ps
package csfw_pkg;

    localparam int COUNT_W = 18;
    localparam int ID_W    = 8;
    localparam int INIT_W  = 16;
    localparam int STS_W   = 3;
    localparam int ACT_W   = 2;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

    localparam logic [ACT_W-1:0] ACT_OPEN   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WAIT   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SIGNAL = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLOSE  = 2'd3;

    localparam logic [STS_W-1:0] STS_GRANTED  = 3'd0;
    localparam logic [STS_W-1:0] STS_BLOCKED  = 3'd1;
    localparam logic [STS_W-1:0] STS_WOKEN    = 3'd2;
    localparam logic [STS_W-1:0] STS_RELEASED = 3'd3;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd4;
    localparam logic [STS_W-1:0] STS_DONE     = 3'd5;

    typedef enum logic
    {
        FSM_IDLE,
        FSM_CLOSE
    } fsm_state_t;

    typedef struct packed
    {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

/* sv/csfw_cell.sv */
// One wait-queue cell: holds an id, loads a new one or takes its neighbor's.
`timescale 1ns / 1ps
module csfw_cell
(
    input  logic                     clk,
    input  csfw_pkg::cell_ctrl_t     ctrl,
    input  logic [csfw_pkg::ID_W-1:0] load_data,
    input  logic [csfw_pkg::ID_W-1:0] neighbor_data,
    output logic [csfw_pkg::ID_W-1:0] data
);

    logic [csfw_pkg::ID_W-1:0] data_reg;
    logic [csfw_pkg::ID_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = neighbor_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* sv/counting_semaphore_fifo_wait_core.sv */
// Counting semaphore with a FIFO wait queue built as a row of shifting cells.
// Each request gives its result in the cycle after acceptance; a close with n
// queued threads releases one thread per cycle while its results are taken,
// and so gives n results (one result with an empty queue). The oldest
// waiter always sits in cell 0; a dequeue shifts the row one cell toward it and
// an enqueue writes the cell at the fill position. The output register lets the
// next request enter while a result waits, as long as that result is taken.
`timescale 1ns / 1ps
`include "counting_semaphore_fifo_wait_core_macros.svh"
module counting_semaphore_fifo_wait_core
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [csfw_pkg::ACT_W-1:0]    action,
    input  logic [csfw_pkg::ID_W-1:0]     thread_id,
    input  logic [csfw_pkg::INIT_W-1:0]   init_value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [csfw_pkg::STS_W-1:0]    status,
    output logic [csfw_pkg::ID_W-1:0]     thread_out,
    output logic                          last
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    csfw_pkg::fsm_state_t state_reg, state_next;
    logic signed [csfw_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic out_valid_reg, out_valid_next;
    logic [csfw_pkg::STS_W-1:0] status_reg, status_next;
    logic [csfw_pkg::ID_W-1:0] thread_reg, thread_next;
    logic last_reg, last_next;

    logic shift_en;
    logic load_en;
    logic out_free;
    logic accept;
    logic close_accept;
    logic signed [csfw_pkg::COUNT_W-1:0] count_dec;
    logic signed [csfw_pkg::COUNT_W-1:0] count_inc;

    logic [csfw_pkg::ID_W-1:0] cell_data [QUEUE_DEPTH];
    csfw_pkg::cell_ctrl_t cell_ctrl [QUEUE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic [csfw_pkg::ID_W-1:0] neighbor;
            if (gi == QUEUE_DEPTH - 1)
            begin : g_end
                assign neighbor = '0;
            end
            else
            begin : g_mid
                assign neighbor = cell_data[gi + 1];
            end
            assign cell_ctrl[gi] = {shift_en, load_en && (fill_reg == FW'(gi))};
            csfw_cell u_cell
            (
                .clk           (clk),
                .ctrl          (cell_ctrl[gi]),
                .load_data     (thread_id),
                .neighbor_data (neighbor),
                .data          (cell_data[gi])
            );
        end
    endgenerate

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != csfw_pkg::FSM_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;
    assign close_accept = accept && (action == csfw_pkg::ACT_CLOSE);
    assign count_dec = (count_reg > csfw_pkg::COUNT_MIN) ? count_reg - 18'sd1
                                                          : csfw_pkg::COUNT_MIN;
    assign count_inc = (count_reg < csfw_pkg::COUNT_MAX) ? count_reg + 18'sd1
                                                          : csfw_pkg::COUNT_MAX;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        status_next    = status_reg;
        thread_next    = thread_reg;
        last_next      = last_reg;
        shift_en       = 1'b0;
        load_en        = 1'b0;
        case (state_reg)
            csfw_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    status_next    = csfw_pkg::STS_DONE;
                    thread_next    = '0;
                    case (action)
                        csfw_pkg::ACT_OPEN:
                        begin
                            count_next = {2'b00, init_value};
                            fill_next  = '0;
                        end
                        csfw_pkg::ACT_WAIT:
                        begin
                            thread_next = thread_id;
                            if (!count_dec[csfw_pkg::COUNT_W-1])
                            begin
                                count_next  = count_dec;
                                status_next = csfw_pkg::STS_GRANTED;
                            end
                            else if (fill_reg == FW'(QUEUE_DEPTH))
                            begin
                                status_next = csfw_pkg::STS_FULL;
                            end
                            else
                            begin
                                count_next  = count_dec;
                                load_en     = 1'b1;
                                fill_next   = fill_reg + FW'(1);
                                status_next = csfw_pkg::STS_BLOCKED;
                            end
                        end
                        csfw_pkg::ACT_SIGNAL:
                        begin
                            count_next = count_inc;
                            if ((count_inc <= 18'sd0) && (fill_reg != '0))
                            begin
                                shift_en    = 1'b1;
                                fill_next   = fill_reg - FW'(1);
                                status_next = csfw_pkg::STS_WOKEN;
                                thread_next = cell_data[0];
                            end
                        end
                        default:
                        begin
                            if (fill_reg != '0)
                            begin
                                shift_en    = 1'b1;
                                fill_next   = fill_reg - FW'(1);
                                status_next = csfw_pkg::STS_RELEASED;
                                thread_next = cell_data[0];
                                last_next   = (fill_reg == FW'(1));
                                if (fill_reg != FW'(1))
                                begin
                                    state_next = csfw_pkg::FSM_CLOSE;
                                end
                            end
                        end
                    endcase
                end
            end
            csfw_pkg::FSM_CLOSE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    shift_en       = 1'b1;
                    fill_next      = fill_reg - FW'(1);
                    status_next    = csfw_pkg::STS_RELEASED;
                    thread_next    = cell_data[0];
                    last_next      = (fill_reg == FW'(1));
                    if (fill_reg == FW'(1))
                    begin
                        state_next = csfw_pkg::FSM_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = csfw_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csfw_pkg::FSM_IDLE;
            count_reg     <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        thread_reg <= thread_next;
        last_reg   <= last_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = status_reg;
    assign thread_out = thread_reg;
    assign last       = last_reg;

    `CSFW_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FW'(QUEUE_DEPTH))
    `CSFW_ASSERT_IMP(a_close_has_waiters, state_reg == csfw_pkg::FSM_CLOSE, fill_reg != '0)
    `CSFW_ASSERT_NXT(a_close_drains, close_accept, fill_reg == '0 || state_reg == csfw_pkg::FSM_CLOSE)

endmodule
